/* design/sha512s_pkg.sv */
// Shared types, constants and round functions for the streaming SHA-512 core.
// Used by sha512s_compress and sha512_stream_hash_core; depends on nothing.
package sha512s_pkg;

	localparam int unsigned WordW   = 64;
	localparam int unsigned BufDep  = 16;
	localparam int unsigned Rounds  = 80;

	localparam logic [63:0] RC [Rounds] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	localparam logic [63:0] IV [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [63:0] PadByte = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic        start;
		logic        wr_en;
		logic [3:0]  wr_addr;
		logic [63:0] wr_data;
		logic        shift;
		logic        reinit;
	} cmp_ctrl_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] head;
	} cmp_stat_t;

	function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

	function automatic logic [63:0] bsig0(input logic [63:0] x);
		bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
	endfunction

	function automatic logic [63:0] bsig1(input logic [63:0] x);
		bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
	endfunction

	function automatic logic [63:0] ssig0(input logic [63:0] x);
		ssig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic logic [63:0] ssig1(input logic [63:0] x);
		ssig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

endpackage

/* design/sha512s_compress.sv */
// SHA-512 compression unit: block buffer memory, chain value memory,
// one round per cycle and a 16-word schedule window. Depends on sha512s_pkg.
module sha512s_compress (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha512s_pkg::cmp_ctrl_t ctrl,
	output sha512s_pkg::cmp_stat_t stat
);

	typedef enum logic [3:0] {
		C_IDLE  = 4'b0001,
		C_PREP  = 4'b0010,
		C_ROUND = 4'b0100,
		C_FOLD  = 4'b1000
	} cst_t;

	cst_t        state_q;
	logic [6:0]  rnd_q;
	logic [2:0]  fold_q;
	logic        done_q;
	logic [63:0] v_q [8];
	logic [63:0] win_q [16];
	logic [63:0] buf_mem [16];
	logic [63:0] buf_rd_q;
	logic [63:0] chain_mem [8];
	logic [63:0] chain_rd_q;
	logic [7:0]  cval_q;
	logic        cval_rd_q;

	logic [3:0]  buf_raddr;
	logic [2:0]  chain_raddr;
	logic [63:0] w_t, sched, t1, t2, cv, fold_sum;
	logic        chain_we;

	always_comb begin
		buf_raddr   = (state_q == C_ROUND) ? (rnd_q[3:0] + 4'd1) : 4'd0;
		chain_raddr = (state_q == C_FOLD) ? (fold_q + 3'd1) : 3'd0;
		sched = win_q[0] + sha512s_pkg::ssig0(win_q[1]) + win_q[9]
			+ sha512s_pkg::ssig1(win_q[14]);
		w_t = (rnd_q < 7'd16) ? buf_rd_q : sched;
		t1 = v_q[7] + sha512s_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ sha512s_pkg::RC[rnd_q] + w_t;
		t2 = sha512s_pkg::bsig0(v_q[0])
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		// An entry not yet written since reinit still holds the initial value.
		cv       = cval_rd_q ? chain_rd_q : sha512s_pkg::IV[fold_q];
		fold_sum = cv + v_q[0];
		chain_we = (state_q == C_FOLD);
	end

	// The buffer is only written while this unit is idle, so reads never collide.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			buf_mem[ctrl.wr_addr] <= ctrl.wr_data;
		end
		buf_rd_q   <= buf_mem[buf_raddr];
		chain_rd_q <= chain_mem[chain_raddr];
		if (chain_we) begin
			chain_mem[fold_q] <= fold_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= w_t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= C_IDLE;
			rnd_q     <= '0;
			fold_q    <= '0;
			done_q    <= 1'b0;
			cval_q    <= '0;
			cval_rd_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= sha512s_pkg::IV[i];
			end
		end else begin
			done_q    <= 1'b0;
			cval_rd_q <= cval_q[chain_raddr];
			unique case (state_q)
				C_IDLE: begin
					if (ctrl.start) begin
						state_q <= C_PREP;
					end
				end
				C_PREP: begin
					rnd_q   <= '0;
					state_q <= C_ROUND;
				end
				C_ROUND: begin
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q  <= rnd_q + 7'd1;
					if (rnd_q == 7'(sha512s_pkg::Rounds - 1)) begin
						fold_q  <= '0;
						state_q <= C_FOLD;
					end
				end
				C_FOLD: begin
					for (int i = 0; i < 7; i++) begin
						v_q[i] <= v_q[i + 1];
					end
					v_q[7]         <= fold_sum;
					cval_q[fold_q] <= 1'b1;
					fold_q         <= fold_q + 3'd1;
					if (fold_q == 3'd7) begin
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
			if (state_q == C_IDLE) begin
				if (ctrl.reinit) begin
					cval_q <= '0;
					for (int i = 0; i < 8; i++) begin
						v_q[i] <= sha512s_pkg::IV[i];
					end
				end else if (ctrl.shift) begin
					for (int i = 0; i < 7; i++) begin
						v_q[i] <= v_q[i + 1];
					end
					v_q[7] <= v_q[0];
				end
			end
		end
	end

	assign stat.busy = (state_q != C_IDLE);
	assign stat.done = done_q;
	assign stat.head = v_q[0];

endmodule

/* design/sha512_stream_hash_core.sv */
// Streaming SHA-512 core: byte packing, padding control and digest output.
// Depends on sha512s_pkg and sha512s_compress.
//
// Use: message words enter on the s_ group. s_tdata carries up to eight bytes,
// big-endian and left-aligned, plus the byte count; s_tlast marks the final
// word of a message. Each request is absorbed as it is accepted. Every 128 bytes
// the compression unit runs a load step, 80 rounds at one round per cycle and
// eight fold steps into the chain value memory, and s_tready stays low while
// it runs and while the core sees the unit finish. Input throughput is thus
// set by the single round datapath: no word is taken during a compression.
// After a last request the core pads (writing pad byte, zeros and length), runs
// one or two more compressions, then sends the eight digest words on the m_
// group, word 0 first, m_tlast on the eighth. Each digest word is one cycle
// when m_tready is high; a stalled receiver holds the output register and
// the core waits. Once the eighth word is loaded the hash state returns to
// the initial value and new input is taken while that word still waits.
// Reset (arst_n low) clears the counters and restores the initial hash value.
module sha512_stream_hash_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // message_word[63:0], byte_count[67:64], zeros
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // digest_word[63:0]
	output logic        m_tlast    // final_word
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CMP  = 5'b00010,
		S_PAD  = 5'b00100,
		S_FILL = 5'b01000,
		S_OUT  = 5'b10000
	} st_t;

	st_t          state_q, ret_q;
	logic [6:0]   fill_q;
	logic [127:0] len_q;
	logic [63:0]  acc_q;
	logic [3:0]   wptr_q;
	logic         extra_q;
	logic [2:0]   ocnt_q;
	logic         m_valid_q, m_last_q;
	logic [63:0]  m_data_q;

	sha512s_pkg::cmp_ctrl_t ctrl;
	sha512s_pkg::cmp_stat_t stat;

	logic         accept;
	logic [3:0]   nbytes, total;
	logic [63:0]  word_m;
	logic [127:0] merged;
	logic         out_load;

	sha512s_compress u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat)
	);

	always_comb begin
		accept   = s_tvalid && s_tready;
		nbytes   = s_tdata[67] ? 4'd8 : s_tdata[67:64];
		word_m   = s_tdata[63:0] & ~(64'hFFFF_FFFF_FFFF_FFFF >> {nbytes, 3'b000});
		merged   = {acc_q, 64'd0} | ({word_m, 64'd0} >> {fill_q[2:0], 3'b000});
		total    = {1'b0, fill_q[2:0]} + nbytes;
		out_load = (state_q == S_OUT) && (!m_valid_q || m_tready);

		ctrl         = '0;
		ctrl.wr_addr = fill_q[6:3];
		ctrl.wr_data = merged[127:64];
		ctrl.shift   = out_load;
		ctrl.reinit  = out_load && (ocnt_q == 3'd7);
		unique case (state_q)
			S_IDLE: begin
				ctrl.wr_en = accept && total[3];
				ctrl.start = accept && total[3] && (fill_q[6:3] == 4'd15);
			end
			S_PAD: begin
				ctrl.wr_en   = 1'b1;
				ctrl.wr_data = acc_q | (sha512s_pkg::PadByte >> {fill_q[2:0], 3'b000});
				ctrl.start   = (fill_q[6:3] == 4'd15);
			end
			S_FILL: begin
				ctrl.wr_en   = 1'b1;
				ctrl.wr_addr = wptr_q;
				ctrl.start   = (wptr_q == 4'd15);
				if (!extra_q && wptr_q == 4'd14) begin
					ctrl.wr_data = len_q[127:64];
				end else if (!extra_q && wptr_q == 4'd15) begin
					ctrl.wr_data = len_q[63:0];
				end else begin
					ctrl.wr_data = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= stat.head;
			m_last_q <= (ocnt_q == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_IDLE;
			fill_q    <= '0;
			len_q     <= '0;
			acc_q     <= '0;
			wptr_q    <= '0;
			extra_q   <= 1'b0;
			ocnt_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						fill_q <= fill_q + {3'b000, nbytes};
						len_q  <= len_q + {121'd0, nbytes, 3'b000};
						acc_q  <= total[3] ? merged[63:0] : merged[127:64];
						if (ctrl.start) begin
							state_q <= S_CMP;
							ret_q   <= s_tlast ? S_PAD : S_IDLE;
						end else if (s_tlast) begin
							state_q <= S_PAD;
						end
					end
				end
				S_CMP: begin
					if (stat.done) begin
						state_q <= ret_q;
					end
				end
				S_PAD: begin
					acc_q <= '0;
					// A pad byte in the last word forces an extra block of zeros and the length.
					if (fill_q[6:3] == 4'd15) begin
						wptr_q  <= '0;
						extra_q <= 1'b0;
						ret_q   <= S_FILL;
						state_q <= S_CMP;
					end else begin
						wptr_q  <= fill_q[6:3] + 4'd1;
						extra_q <= (fill_q[6:3] == 4'd14);
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					wptr_q <= wptr_q + 4'd1;
					if (wptr_q == 4'd15) begin
						ret_q   <= extra_q ? S_FILL : S_OUT;
						extra_q <= 1'b0;
						state_q <= S_CMP;
					end
				end
				S_OUT: begin
					if (out_load) begin
						m_valid_q <= 1'b1;
						ocnt_q    <= ocnt_q + 3'd1;
						if (ocnt_q == 3'd7) begin
							fill_q  <= '0;
							len_q   <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> !stat.busy)
		else $error("compression started while busy");
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_en |-> !stat.busy)
		else $error("buffer written during compression");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> state_q == S_CMP)
		else $error("compression finished with no request waiting");
	a_last_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && ocnt_q == 3'd7 |=> m_tvalid && m_tlast && state_q == S_IDLE)
		else $error("final digest word not flagged");
`endif

endmodule
